// ===== rtl/core/ilp_pkg.sv =====
// shared types and character codes for the integer literal parser
package ilp_pkg;

   localparam int unsigned ValueWidth = 32;

   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_UP_A  = 8'h41;
   localparam logic [7:0] CH_UP_B  = 8'h42;
   localparam logic [7:0] CH_UP_F  = 8'h46;
   localparam logic [7:0] CH_UP_X  = 8'h58;
   localparam logic [7:0] CH_LO_A  = 8'h61;
   localparam logic [7:0] CH_LO_B  = 8'h62;
   localparam logic [7:0] CH_LO_F  = 8'h66;
   localparam logic [7:0] CH_LO_X  = 8'h78;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_SIGN   = 3'd1,
      PH_ZERO   = 3'd2,
      PH_DIGITS = 3'd3
   } phase_type;

   typedef enum logic [1:0] {
      RX_DEC = 2'd0,
      RX_HEX = 2'd1,
      RX_BIN = 2'd2,
      RX_OCT = 2'd3
   } radix_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       start_req;
   } req_type;

   typedef struct packed {
      logic signed [ValueWidth-1:0] value;
      logic [1:0]                   radix;
   } rsp_type;

   typedef struct packed {
      phase_type             phase;
      logic                  negative;
      radix_type             radix_sel;
      logic [ValueWidth-1:0] accum;
   } parse_state_type;

endpackage

// ===== rtl/core/ilp_step.sv =====
// next-state and result logic for one character of a literal
module ilp_step
   import ilp_pkg::*;
(
   input  parse_state_type cur,
   input  req_type         item,
   output parse_state_type nxt,
   output logic            emit,
   output rsp_type         result
);

   function automatic logic [4:0] digit_decode(logic [7:0] c, radix_type rx);
      logic [3:0] d;
      logic       ok;
      begin
         d  = 4'd0;
         ok = 1'b0;
         if (c inside {[CH_ZERO:CH_NINE]}) begin
            d  = c[3:0];
            ok = 1'b1;
         end else if (c inside {[CH_UP_A:CH_UP_F]}) begin
            d  = 4'(c - CH_UP_A + 8'd10);
            ok = 1'b1;
         end else if (c inside {[CH_LO_A:CH_LO_F]}) begin
            d  = 4'(c - CH_LO_A + 8'd10);
            ok = 1'b1;
         end
         case (rx)
            RX_DEC: ok = ok && (d < 4'd10);
            RX_HEX: ok = ok;
            RX_BIN: ok = ok && (d < 4'd2);
            RX_OCT: ok = ok && (d < 4'd8);
            default: ok = 1'b0;
         endcase
         return {ok, d};
      end
   endfunction

   parse_state_type        st;
   logic                   take;
   logic [4:0]             dig;
   logic [ValueWidth-1:0]  scaled;

   always_comb begin
      st     = cur;
      take   = 1'b0;
      emit   = 1'b0;
      result = '0;
      if (item.start_req) begin
         st.negative  = 1'b0;
         st.radix_sel = RX_DEC;
         st.accum     = '0;
         st.phase     = PH_SIGN;
      end
      if (item.start_req && item.ch == CH_MINUS) begin
         st.negative = 1'b1;
      end else begin
         case (st.phase)
            PH_SIGN: begin
               if (item.ch == CH_ZERO) begin
                  st.phase = PH_ZERO;
               end else begin
                  st.radix_sel = RX_DEC;
                  st.phase     = PH_DIGITS;
                  take         = 1'b1;
               end
            end
            PH_ZERO: begin
               st.phase = PH_DIGITS;
               if (item.ch == CH_UP_X || item.ch == CH_LO_X) begin
                  st.radix_sel = RX_HEX;
               end else if (item.ch == CH_UP_B || item.ch == CH_LO_B) begin
                  st.radix_sel = RX_BIN;
               end else begin
                  st.radix_sel = RX_OCT;
                  take         = 1'b1;
               end
            end
            PH_DIGITS: take = 1'b1;
            default:   st.phase = PH_IDLE;
         endcase
      end

      dig = digit_decode(item.ch, st.radix_sel);
      case (st.radix_sel)
         RX_DEC:  scaled = (st.accum << 3) + (st.accum << 1);
         RX_HEX:  scaled = st.accum << 4;
         RX_BIN:  scaled = st.accum << 1;
         RX_OCT:  scaled = st.accum << 3;
         default: scaled = st.accum;
      endcase

      if (take) begin
         if (dig[4]) begin
            st.accum = scaled + ValueWidth'(dig[3:0]);
         end else begin
            emit         = 1'b1;
            result.value = st.negative ? signed'(ValueWidth'(-st.accum))
                                       : signed'(st.accum);
            result.radix = st.radix_sel;
            st.phase     = PH_IDLE;
         end
      end
      nxt = st;
   end

endmodule

// ===== rtl/core/integer_literal_parser_unit.sv =====
// top level of the streaming integer literal parser
// Takes one character per request and reports a signed 32-bit value with its
// radix code when the first non-digit ends a literal. A request with start_req
// set begins a new literal and drops any unfinished one; an optional '-' then a
// leading '0' with x/X or b/B select hex or binary, a bare leading '0' octal,
// otherwise decimal. One request can be taken every cycle unless req_stall is
// high; the request that ends the literal goes through the input register, then
// the single-pass digit accumulate into the result register. req_stall rises
// only while a result waits under rsp_stall and the input register is occupied.
module integer_literal_parser_unit
   import ilp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp
);

   req_type         item_ff;
   logic            item_valid_ff, item_valid_in;
   parse_state_type state_ff, state_in;
   rsp_type         rsp_ff, rsp_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            advance;
   logic            emit;
   logic            req_take;

   ilp_step u_ilp_step (
      .cur    (state_ff),
      .item   (item_ff),
      .nxt    (state_in),
      .emit   (emit),
      .result (rsp_in)
   );

   assign advance   = item_valid_ff && !(rsp_valid_ff && rsp_stall);
   assign req_stall = item_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      if (req_take) begin
         item_valid_in = 1'b1;
      end else if (advance) begin
         item_valid_in = 1'b0;
      end else begin
         item_valid_in = item_valid_ff;
      end
      if (advance && emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase     <= PH_IDLE;
         state_ff.negative  <= 1'b0;
         state_ff.radix_sel <= RX_DEC;
         state_ff.accum     <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff <= req;
      end
      if (advance && emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// ===== rtl/core/ilp_checker.sv =====
// port-level checks for the integer literal parser, bound to the top level
module ilp_checker
   import ilp_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp
);

   // held result keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
      else $error("result changed while stalled");

   // backpressure only passes through from a stalled result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without result stall");

   // a fresh result needs an earlier accepted request
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
      else $error("result without a request");

endmodule

bind integer_literal_parser_unit ilp_checker u_ilp_checker (.*);

// ===== bench/tb_top.sv =====
// testbench for the integer literal parser: directed and random literals checked in order
`timescale 1ns / 1ps

module tb_top;
   import ilp_pkg::*;

   localparam int CycleLimit = 400000;
   localparam int ParsedTarget = 1850;

   class literal_scoreboard;
      phase_type   phase;
      logic        negative;
      radix_type   radix_sel;
      logic [31:0] accum;
      rsp_type     expected_q[$];
      int          errors;

      function new();
         phase = PH_IDLE;
         negative = 1'b0;
         radix_sel = RX_DEC;
         accum = '0;
         errors = 0;
      endfunction

      function int base_of(radix_type r);
         case (r)
            RX_HEX: return 16;
            RX_BIN: return 2;
            RX_OCT: return 8;
            default: return 10;
         endcase
      endfunction

      function int digit_value(logic [7:0] c, int base);
         int d;
         if (c >= CH_ZERO && c <= CH_NINE) d = int'(c) - int'(CH_ZERO);
         else if (c >= CH_UP_A && c <= CH_UP_F) d = int'(c) - int'(CH_UP_A) + 10;
         else if (c >= CH_LO_A && c <= CH_LO_F) d = int'(c) - int'(CH_LO_A) + 10;
         else return -1;
         return (d < base) ? d : -1;
      endfunction

      function void take_char(logic [7:0] c);
         int base;
         int d;
         rsp_type e;
         base = base_of(radix_sel);
         d = digit_value(c, base);
         if (d >= 0) begin
            accum = accum * 32'(base) + 32'(d);
         end else begin
            e.value = negative ? 32'(32'd0 - accum) : accum;
            e.radix = radix_sel;
            expected_q.push_back(e);
            phase = PH_IDLE;
         end
      endfunction

      // returns 1 when the request is parsed, 0 when it is ignored
      function bit note_request(req_type r);
         logic [7:0] c;
         c = r.ch;
         if (r.start_req) begin
            negative = 1'b0;
            radix_sel = RX_DEC;
            accum = '0;
            phase = PH_SIGN;
            if (c == CH_MINUS) begin
               negative = 1'b1;
               return 1'b1;
            end
         end
         case (phase)
            PH_SIGN: begin
               if (c == CH_ZERO) begin
                  phase = PH_ZERO;
               end else begin
                  radix_sel = RX_DEC;
                  phase = PH_DIGITS;
                  take_char(c);
               end
            end
            PH_ZERO: begin
               phase = PH_DIGITS;
               if (c == CH_UP_X || c == CH_LO_X) begin
                  radix_sel = RX_HEX;
               end else if (c == CH_UP_B || c == CH_LO_B) begin
                  radix_sel = RX_BIN;
               end else begin
                  radix_sel = RX_OCT;
                  take_char(c);
               end
            end
            PH_DIGITS: take_char(c);
            default: begin
               phase = PH_IDLE;
               return 1'b0;
            end
         endcase
         return 1'b1;
      endfunction

      function void check_result(rsp_type got);
         rsp_type e;
         if (expected_q.size() == 0) begin
            $error("unexpected result: value %0d radix %0d", got.value, got.radix);
            errors++;
            return;
         end
         e = expected_q.pop_front();
         if (got.value !== e.value) begin
            $error("value: expected %0d, got %0d", e.value, got.value);
            errors++;
         end
         if (got.radix !== e.radix) begin
            $error("radix: expected %0d, got %0d", e.radix, got.radix);
            errors++;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic    clock;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp;

   literal_scoreboard board;
   int         send_idle_pct = 0;
   int         recv_stall_pct = 0;
   int         parsed_count = 0;
   int         cycle_count = 0;
   logic [7:0] text_q[$];

   integer_literal_parser_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("FAIL");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_result(rsp);
   end

   // called at a falling edge, returns at a falling edge
   task automatic send_char(input logic [7:0] c, input logic s);
      req_type r;
      r.ch = c;
      r.start_req = s;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (board.note_request(r)) parsed_count++;
      @(negedge clock);
   endtask

   task automatic send_text();
      foreach (text_q[i]) send_char(text_q[i], i == 0);
   endtask

   task automatic send_literal();
      radix_type rx;
      int n;
      int v;
      rx = radix_type'($urandom_range(3));
      n = ($urandom_range(19) == 0) ? $urandom_range(12, 24) : $urandom_range(0, 8);
      text_q = {};
      if ($urandom_range(2) == 0) text_q.push_back(CH_MINUS);
      case (rx)
         RX_HEX: begin
            text_q.push_back(CH_ZERO);
            text_q.push_back($urandom_range(1) ? CH_UP_X : CH_LO_X);
         end
         RX_BIN: begin
            text_q.push_back(CH_ZERO);
            text_q.push_back($urandom_range(1) ? CH_UP_B : CH_LO_B);
         end
         RX_OCT: text_q.push_back(CH_ZERO);
         default: ;
      endcase
      for (int i = 0; i < n; i++) begin
         case (rx)
            RX_HEX: begin
               v = $urandom_range(15);
               if (v < 10) text_q.push_back(CH_ZERO + 8'(v));
               else text_q.push_back(($urandom_range(1) ? CH_UP_A : CH_LO_A) + 8'(v - 10));
            end
            RX_BIN: text_q.push_back(CH_ZERO + 8'($urandom_range(1)));
            RX_OCT: text_q.push_back(CH_ZERO + 8'($urandom_range(7)));
            default: text_q.push_back(CH_ZERO + 8'($urandom_range(9, (i == 0) ? 1 : 0)));
         endcase
      end
      // a missing terminator leaves the parse to be dropped by the next start
      if ($urandom_range(99) < 88) text_q.push_back(8'($urandom_range(255)));
      if (text_q.size() == 0) text_q.push_back(8'($urandom_range(255)));
      send_text();
   endtask

   initial begin
      board = new();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_char(CH_ZERO + 8'd5, 1'b0);
      text_q = '{CH_MINUS, CH_ZERO, CH_LO_X, CH_LO_A, CH_UP_F, 8'h67};
      send_text();
      text_q = '{CH_ZERO, CH_UP_B, CH_ZERO + 8'd1, CH_ZERO, CH_ZERO + 8'd2};
      send_text();
      text_q = '{CH_ZERO, CH_ZERO + 8'd7, CH_ZERO + 8'd8};
      send_text();
      text_q = '{CH_NINE, CH_LO_A};
      send_text();
      text_q = '{CH_MINUS, CH_MINUS};
      send_text();
      text_q = '{CH_UP_X};
      send_text();
      text_q = '{CH_ZERO, CH_UP_X, 8'hFF};
      send_text();
      text_q = '{CH_ZERO + 8'd1};
      send_text();
      text_q = '{CH_ZERO + 8'd2, 8'h00};
      send_text();

      for (int p = 0; p < 3; p++) begin
         send_idle_pct = (p == 0) ? 17 : (p == 1) ? 73 : 0;
         recv_stall_pct = (p == 0) ? 73 : (p == 1) ? 17 : 0;
         while (parsed_count < (p + 1) * ParsedTarget / 3) begin
            if ($urandom_range(99) < 8) begin
               repeat ($urandom_range(1, 4))
                  send_char(8'($urandom_range(255)), $urandom_range(3) == 0);
            end else begin
               send_literal();
            end
         end
         // hold off until the pipeline has drained
         req_valid <= 1'b0;
         @(negedge clock);
         while (board.pending() != 0) @(negedge clock);
      end

      repeat (8) @(posedge clock);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
